@@ design/lzhc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzhc_pkg
// Shared types and constants of the LZ77 hash chain match finder.
// ----------------------------------------------------------------------------
package lzhc_pkg;

  localparam int unsigned DEF_HASH_BITS     = 15;
  localparam int unsigned DEF_WINDOW_SIZE   = 65536;
  localparam int unsigned DEF_MAX_MATCH     = 258;
  localparam int unsigned DEF_HISTORY_DEPTH = 131072;

  localparam int unsigned MIN_MATCH = 4;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned OFF_W   = 17;
  localparam int unsigned OLEN_W  = 9;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ENTRY_W = POS_W + 1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FIND   = 2'd1,
    OP_INSERT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BYTE_RD,
    ST_BYTE_WT,
    ST_HASH_MUL,
    ST_HEAD_RD,
    ST_HEAD_WT,
    ST_WALK,
    ST_CMP_RD,
    ST_CMP_WT,
    ST_CMP_END,
    ST_LINK_RD,
    ST_LINK_WT,
    ST_INSERT,
    ST_RESULT
  } state_t;

endpackage

@@ design/lz_hash_chain_match_finder_top.sv @@
// ----------------------------------------------------------------------------
// lz_hash_chain_match_finder_top
// LZ77 match finder with a hash chain over an append-only byte history.
// ----------------------------------------------------------------------------
// Usage: beats on the in_ channel carry an operation in in_tuser. An append
// beat writes one byte; appends can follow back to back. A find or insert
// beat reads the four bytes at the position, hashes them in a multiplier
// step and reads the chain head. A find then walks the chain: an entry
// inside the window is first compared byte by byte (the matching bytes, up
// to the maximum length, and the first mismatching one), since both history
// bytes come out of one dual-read memory and are compared serially; then the
// link of each visited entry is read. A maximum-length match ends the walk at
// once. The insert step then writes the head and the link; a find then loads
// its result register. A find whose four bytes are not yet all in the history
// goes straight from acceptance to its result step. in_tready is low while an
// item is at work.
// The result sits in an output register; the next item is accepted while it
// waits, and a later find holds in its result step while out_tready is low.
// After reset the chain head table is cleared, one entry per cycle, over all
// 2^HASH_BITS entries (32768 by default); in_tready stays low meanwhile.
// cfg_data (chain_limit) is always accepted and takes effect at once; the user
// must write it only while no item is at work; the block does not enforce it.
// ----------------------------------------------------------------------------
module lz_hash_chain_match_finder_top
  import lzhc_pkg::*;
#(
  parameter int unsigned HASH_BITS     = DEF_HASH_BITS,
  parameter int unsigned WINDOW_SIZE   = DEF_WINDOW_SIZE,
  parameter int unsigned MAX_MATCH     = DEF_MAX_MATCH,
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,   // byte_value[7:0], position[39:8]
  input  logic [1:0]         in_tuser,   // operation[1:0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,  // match_offset[16:0], match_length[25:17]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned WIN_AW  = $clog2(WINDOW_SIZE);
  localparam int unsigned LEN_W   = $clog2(MAX_MATCH + 1);
  localparam int unsigned HEADS   = 1 << HASH_BITS;

  state_t state_r, state_nxt;

  logic [7:0]         hist_mem [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] head_mem [HEADS];
  logic [ENTRY_W-1:0] link_mem [WINDOW_SIZE];

  logic [7:0]         hist_qa, hist_qb;
  logic [ENTRY_W-1:0] head_q, link_q;
  logic [HIST_AW-1:0] addr_a, addr_b;
  logic [HASH_BITS-1:0] head_raddr, head_waddr;
  logic [ENTRY_W-1:0] head_wdata;
  logic               head_we, link_we;

  logic [POS_W-1:0]   stream_len_r;
  logic [LIMIT_W-1:0] chain_limit_r;
  logic [HASH_BITS:0] clr_r;
  op_t                op_r;
  logic [POS_W-1:0]   pos_r;
  logic [1:0]         k_r;
  logic [31:0]        word_r, prod_r;
  logic [HASH_BITS-1:0] hash_r;
  logic [ENTRY_W-1:0] entry_r, head_r;
  logic [LIMIT_W-1:0] steps_r;
  logic [LEN_W-1:0]   len_r, max_len_r, best_len_r;
  logic [OFF_W-1:0]   best_off_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic               accept;
  op_t                in_op;
  logic [POS_W-1:0]   in_pos;
  logic               fits;
  logic [POS_W:0]     avail;
  logic [POS_W-1:0]   cand;
  logic [POS_W:0]     diff;
  logic               in_win, walk_go, eq, more;

  assign in_op  = op_t'(in_tuser);
  assign in_pos = in_tdata[39:8];
  assign accept = in_tvalid && in_tready;
  assign fits   = ({1'b0, in_pos} + (POS_W + 1)'(MIN_MATCH)) <= {1'b0, stream_len_r};
  assign avail  = {1'b0, stream_len_r} - {1'b0, in_pos};

  assign cand    = entry_r[POS_W-1:0];
  assign diff    = {1'b0, pos_r} - {1'b0, cand};
  assign in_win  = (cand < pos_r) && (diff <= (POS_W + 1)'(WINDOW_SIZE));
  assign walk_go = entry_r[POS_W] && (steps_r < chain_limit_r);
  assign eq      = hist_qa == hist_qb;
  assign more    = (len_r + LEN_W'(1)) < max_len_r;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (clr_r[HASH_BITS]) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && (in_op == OP_FIND || in_op == OP_INSERT)) begin
          if (fits) state_nxt = ST_BYTE_RD;
          else if (in_op == OP_FIND) state_nxt = ST_RESULT;
        end
      end
      ST_BYTE_RD:  state_nxt = ST_BYTE_WT;
      ST_BYTE_WT:  state_nxt = (k_r == 2'd3) ? ST_HASH_MUL : ST_BYTE_RD;
      ST_HASH_MUL: state_nxt = ST_HEAD_RD;
      ST_HEAD_RD:  state_nxt = ST_HEAD_WT;
      ST_HEAD_WT:  state_nxt = (op_r == OP_FIND) ? ST_WALK : ST_INSERT;
      ST_WALK: begin
        if (!walk_go) state_nxt = ST_INSERT;
        else if (in_win) state_nxt = ST_CMP_RD;
        else state_nxt = ST_LINK_RD;
      end
      ST_CMP_RD:   state_nxt = ST_CMP_WT;
      ST_CMP_WT:   state_nxt = (eq && more) ? ST_CMP_RD : ST_CMP_END;
      ST_CMP_END: begin
        if (len_r >= LEN_W'(MIN_MATCH) && len_r > best_len_r &&
            len_r == LEN_W'(MAX_MATCH)) state_nxt = ST_INSERT;
        else state_nxt = ST_LINK_RD;
      end
      ST_LINK_RD:  state_nxt = ST_LINK_WT;
      ST_LINK_WT:  state_nxt = ST_WALK;
      ST_INSERT:   state_nxt = (op_r == OP_FIND) ? ST_RESULT : ST_IDLE;
      ST_RESULT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // Memory ports and handshake.
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    addr_a     = pos_r[HIST_AW-1:0] + HIST_AW'(len_r);
    addr_b     = cand[HIST_AW-1:0] + HIST_AW'(len_r);
    head_raddr = prod_r[31 -: HASH_BITS];
    head_we    = 1'b0;
    head_waddr = hash_r;
    head_wdata = {1'b1, pos_r};
    link_we    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        head_we    = !clr_r[HASH_BITS];
        head_waddr = clr_r[HASH_BITS-1:0];
        head_wdata = '0;
      end
      ST_BYTE_RD: addr_a = pos_r[HIST_AW-1:0] + HIST_AW'(k_r);
      ST_INSERT: begin
        head_we = 1'b1;
        link_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_APPEND) begin
      hist_mem[stream_len_r[HIST_AW-1:0]] <= in_tdata[7:0];
    end
    hist_qa <= hist_mem[addr_a];
    hist_qb <= hist_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[pos_r[WIN_AW-1:0]] <= head_r;
    end
    link_q <= link_mem[cand[WIN_AW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      stream_len_r  <= '0;
      chain_limit_r <= LIMIT_W'(64);
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) chain_limit_r <= cfg_data;
      if (accept && in_op == OP_APPEND) stream_len_r <= stream_len_r + 1'b1;
      if (state_r == ST_RESULT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        op_r       <= in_op;
        pos_r      <= in_pos;
        k_r        <= '0;
        best_len_r <= '0;
        best_off_r <= '0;
        max_len_r  <= (avail > (POS_W + 1)'(MAX_MATCH)) ? LEN_W'(MAX_MATCH)
                                                         : avail[LEN_W-1:0];
      end
      ST_BYTE_WT: begin
        word_r <= {hist_qa, word_r[31:8]};
        k_r    <= k_r + 1'b1;
      end
      ST_HASH_MUL: prod_r <= word_r * HASH_MULT;
      ST_HEAD_RD:  hash_r <= head_raddr;
      ST_HEAD_WT: begin
        entry_r <= head_q;
        head_r  <= head_q;
        steps_r <= '0;
      end
      ST_WALK:  len_r <= '0;
      ST_CMP_WT: if (eq) len_r <= len_r + 1'b1;
      ST_CMP_END: begin
        if (len_r >= LEN_W'(MIN_MATCH) && len_r > best_len_r) begin
          best_len_r <= len_r;
          best_off_r <= diff[OFF_W-1:0];
        end
      end
      ST_LINK_WT: begin
        entry_r <= link_q;
        steps_r <= steps_r + 1'b1;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {6'd0, OLEN_W'(best_len_r), best_off_r};
        end
      end
      default: ;
    endcase
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input accepted during head table clear");

  a_best_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT && best_len_r != '0) |-> best_len_r >= LEN_W'(MIN_MATCH))
    else $error("best match shorter than minimum");

  a_off_len_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[16:0] == '0) == (out_data_r[25:17] == '0)))
    else $error("offset and length disagree on match presence");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("result step left without loading the output");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZ77 hash chain match finder. A stream of
// appends, finds and inserts is driven through the input channel; a local
// model of the history, heads and links predicts every find result, which
// the monitor compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import lzhc_pkg::*;

  localparam int unsigned HBITS  = DEF_HASH_BITS;
  localparam int unsigned WIN    = DEF_WINDOW_SIZE;
  localparam int unsigned MAXM   = DEF_MAX_MATCH;
  localparam int unsigned HDEPTH = DEF_HISTORY_DEPTH;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic [31:0] pos;
  } beat_t;

  typedef struct packed {
    logic [16:0] offset;
    logic [8:0]  length;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0] in_tuser = OP_APPEND;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  lz_hash_chain_match_finder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state.
  logic [7:0]  hist [HDEPTH];
  logic [32:0] heads [1 << HBITS];
  logic [32:0] links [WIN];
  logic [31:0] stream_len;
  int unsigned walk_limit;

  beat_t  pending_beats[$];
  match_t expected_matches[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;

  function automatic logic [7:0] hist_byte(logic [32:0] p);
    return hist[p % HDEPTH];
  endfunction

  function automatic logic [HBITS-1:0] hash4(logic [31:0] p);
    logic [31:0] word;
    logic [31:0] prod;
    word = {hist_byte(p + 33'd3), hist_byte(p + 33'd2), hist_byte(p + 33'd1), hist_byte(p)};
    prod = word * HASH_MULT;
    return prod[31:32-HBITS];
  endfunction

  function automatic bit room_at(logic [31:0] p);
    return ({1'b0, p} + 33'd4) <= {1'b0, stream_len};
  endfunction

  function automatic void chain_insert(logic [31:0] p, logic [HBITS-1:0] h);
    links[p % WIN] = heads[h];
    heads[h] = {1'b1, p};
  endfunction

  // Applies one beat to the model; a find pushes its expected result.
  function automatic void predict(beat_t b);
    logic [HBITS-1:0] h;
    logic [32:0] entry;
    logic [31:0] cand;
    int unsigned steps, mlen, len, best_len;
    logic [31:0] best_off;
    longint unsigned avail;
    match_t m;
    case (b.op)
      OP_APPEND: begin
        hist[stream_len % HDEPTH] = b.value;
        stream_len = stream_len + 1;
      end
      OP_INSERT: if (room_at(b.pos)) chain_insert(b.pos, hash4(b.pos));
      OP_FIND: begin
        best_off = 0;
        best_len = 0;
        if (room_at(b.pos)) begin
          h = hash4(b.pos);
          entry = heads[h];
          steps = 0;
          avail = longint'(stream_len) - longint'(b.pos);
          mlen = (avail > MAXM) ? MAXM : int'(avail);
          while (entry[32] && steps < walk_limit) begin
            cand = entry[31:0];
            if (cand < b.pos && (b.pos - cand) <= WIN) begin
              len = 0;
              while (len < mlen &&
                     hist_byte({1'b0, b.pos} + len) == hist_byte({1'b0, cand} + len))
                len++;
              if (len >= MIN_MATCH && len > best_len) begin
                best_off = b.pos - cand;
                best_len = len;
                if (len == MAXM) break;
              end
            end
            entry = links[cand % WIN];
            steps++;
          end
          chain_insert(b.pos, h);
        end
        m.offset = best_off[16:0];
        m.length = best_len[8:0];
        expected_matches.push_back(m);
      end
      default: ;
    endcase
  endfunction

  // Driver: predicts each beat as it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict(beat_t'({op_t'(in_tuser), in_tdata[7:0], in_tdata[39:8]}));
      if (!(in_tvalid && !in_tready)) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_t b;
          b = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= b.op;
          in_tdata  <= {b.pos, b.value};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        match_t got, want;
        got = {out_tdata[16:0], out_tdata[25:17]};
        if (expected_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = expected_matches.pop_front();
          if (got.offset !== want.offset || got.length !== want.length ||
              out_tdata[31:26] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp offset %0d length %0d, got offset %0d length %0d",
                       want.offset, want.length, got.offset, got.length);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_beat(op_t op, logic [7:0] v, logic [31:0] p);
    beat_t b;
    b.op = op;
    b.value = v;
    b.pos = p;
    pending_beats.push_back(b);
  endtask

  // Waits until everything is sent and answered and the block is idle again.
  // Sampling just after the edge sees the values that the edge settled.
  task automatic drain();
    @(posedge clk);
    #1;
    while (pending_beats.size() != 0 || in_tvalid || !in_tready ||
           expected_matches.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic write_limit(int unsigned v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[LIMIT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    walk_limit = v;
    cfg_valid <= 1'b0;
  endtask

  // Planned stream length, tracked while queuing so positions stay sensible.
  int unsigned planned_len = 0;

  task automatic queue_append(logic [7:0] v);
    push_beat(OP_APPEND, v, $urandom());
    planned_len++;
  endtask

  // Appends phrases drawn mostly from the byte values 0 to 3, mixed with finds
  // and inserts around them.
  task automatic queue_random(int unsigned n);
    int unsigned i, k, len, src;
    logic [31:0] p;
    i = 0;
    while (i < n) begin
      k = $urandom_range(99);
      if (k < 55) begin
        len = $urandom_range(1, 12);
        src = (planned_len > 40) ? $urandom_range(1, 40) : 0;
        repeat (len) begin
          queue_append((src != 0 && $urandom_range(3) != 0) ?
                       8'($urandom_range(3)) : 8'($urandom()));
          i++;
        end
      end else begin
        if ($urandom_range(9) == 0) p = $urandom();
        else if (planned_len > 0) p = planned_len - $urandom_range(1, planned_len > 300 ? 300 : planned_len);
        else p = 0;
        k = $urandom_range(19);
        push_beat(k < 14 ? OP_FIND : (k < 19 ? OP_INSERT : OP_NONE), $urandom(), p);
        i++;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    foreach (heads[i]) heads[i] = '0;
    foreach (links[i]) links[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    stream_len = 0;
    walk_limit = 64;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty finds, a run of equal bytes for a maximum match, ties.
    push_beat(OP_FIND, 8'hFF, 32'd0);
    push_beat(OP_INSERT, 8'h00, 32'hFFFF_FFFF);
    push_beat(OP_FIND, 8'h00, 32'hFFFF_FFFF);
    push_beat(OP_NONE, 8'hA5, 32'h5A5A_5A5A);
    for (int i = 0; i < 600; i++) queue_append(8'h00);
    push_beat(OP_INSERT, 8'h00, 32'd0);
    push_beat(OP_FIND, 8'h00, 32'd1);
    push_beat(OP_FIND, 8'h00, 32'd300);
    push_beat(OP_FIND, 8'h00, 32'd597);
    push_beat(OP_FIND, 8'h00, 32'd596);
    queue_append(8'hFF);
    push_beat(OP_FIND, 8'h00, 32'd590);
    push_beat(OP_FIND, 8'h00, 32'd2);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_limit(1);    end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  write_limit(4096); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; write_limit(0);    end
        3: begin send_idle_pct = 35; recv_stall_pct = 35; write_limit(8191); end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_limit(3);    end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; write_limit(64); end
      endcase
      queue_random(165);
      drain();
    end

    if (mismatches == 0 && expected_matches.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #1s;
    $display("status: fail");
    $finish;
  end

endmodule
